### hdl/q16dt_pkg.sv
// shared constants and types for the 16.16 fixed point to decimal text converter
package q16dt_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned IntWidth   = 16;
  localparam int unsigned FracWidth  = 16;
  localparam int unsigned BcdDigits  = 5;
  localparam int unsigned BcdWidth   = 4 * BcdDigits;
  localparam int unsigned FracDigits = 6;
  localparam int unsigned CharWidth  = 7;

  localparam logic [CharWidth-1:0] CharMinus = 7'h2D;
  localparam logic [CharWidth-1:0] CharDot   = 7'h2E;
  localparam logic [CharWidth-1:0] CharZero  = 7'h30;
  localparam logic [CharWidth-1:0] CharNine  = 7'h39;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CONV = 7'b0000010,
    ST_SKIP = 7'b0000100,
    ST_SIGN = 7'b0001000,
    ST_INT  = 7'b0010000,
    ST_DOT  = 7'b0100000,
    ST_FRAC = 7'b1000000
  } state_e;

endpackage

### hdl/q16dt_bin2bcd.sv
// bit-serial binary to bcd converter (shift and add-3), one bit per cycle
module q16dt_bin2bcd
  import q16dt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic [IntWidth-1:0] bin_i,
  output logic [BcdWidth-1:0] bcd_o,
  output logic                done_o
);

  localparam int unsigned CntWidth = $clog2(IntWidth + 1);

  logic [IntWidth-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0] bcd_q, bcd_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [BcdWidth-1:0] adj;

  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (load_i) begin
      bin_d = bin_i;
      bcd_d = '0;
      cnt_d = CntWidth'(IntWidth);
    end else if (cnt_q != '0) begin
      bcd_d = {adj[BcdWidth-2:0], bin_q[IntWidth-1]};
      bin_d = {bin_q[IntWidth-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign bcd_o  = bcd_q;
  assign done_o = (cnt_q == '0);

endmodule

### hdl/q16_16_to_decimal_text.sv
// top level: signed 16.16 fixed point value to ascii decimal text, one character per beat
//
// Pulse start while busy is low to hand over value_i. The text leaves as one character
// per beat on char_code_o, each beat marked by char_strobe_o for exactly one cycle and
// never held off; last_char_o flags the final character. The text is an optional minus
// sign, the integer part without leading zeros, a point and six truncated fraction
// digits. The integer part goes through a 16-step bit-serial binary to bcd converter
// and the fraction digits come out of a times-ten step on a 16-bit remainder, one digit
// per cycle. The characters of a number leave in consecutive cycles.
module q16_16_to_decimal_text
  import q16dt_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [ValueWidth-1:0] value_i,
  output logic                         char_strobe_o,
  output logic        [CharWidth-1:0]  char_code_o,
  output logic                         last_char_o
);

  localparam int unsigned IdxWidth  = $clog2(BcdDigits);
  localparam int unsigned FcntWidth = $clog2(FracDigits + 1);

  state_e               state_q, state_d;
  logic                 neg_q, neg_d;
  logic [FracWidth-1:0] frac_q, frac_d;
  logic [IdxWidth-1:0]  idx_q, idx_d;
  logic [FcntWidth-1:0] fcnt_q, fcnt_d;

  logic                 strobe_q, strobe_d;
  logic [CharWidth-1:0] code_q, code_d;
  logic                 last_q, last_d;

  logic                  accept;
  logic [ValueWidth-1:0] raw;
  logic [ValueWidth-1:0] mag;
  logic [BcdWidth-1:0]   bcd;
  logic                  conv_done;
  logic [3:0]            int_digit;
  logic [FracWidth+3:0]  frac_x10;

  assign accept = start && !busy;
  assign raw    = value_i;
  assign mag    = raw[ValueWidth-1] ? (~raw + 1'b1) : raw;

  q16dt_bin2bcd u_bin2bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .bin_i  (mag[ValueWidth-1 -: IntWidth]),
    .bcd_o  (bcd),
    .done_o (conv_done)
  );

  assign int_digit = bcd[{idx_q, 2'b00} +: 4];
  assign frac_x10  = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};

  always_comb begin
    state_d  = state_q;
    neg_d    = neg_q;
    frac_d   = frac_q;
    idx_d    = idx_q;
    fcnt_d   = fcnt_q;
    strobe_d = 1'b0;
    code_d   = code_q;
    last_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          neg_d   = raw[ValueWidth-1];
          frac_d  = mag[FracWidth-1:0];
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          idx_d   = IdxWidth'(BcdDigits - 1);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (idx_q != '0 && int_digit == 4'd0) begin
          idx_d = idx_q - 1'b1;
        end else begin
          state_d = neg_q ? ST_SIGN : ST_INT;
        end
      end
      ST_SIGN: begin
        strobe_d = 1'b1;
        code_d   = CharMinus;
        state_d  = ST_INT;
      end
      ST_INT: begin
        strobe_d = 1'b1;
        code_d   = CharZero + CharWidth'(int_digit);
        if (idx_q == '0) begin
          state_d = ST_DOT;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      ST_DOT: begin
        strobe_d = 1'b1;
        code_d   = CharDot;
        fcnt_d   = FcntWidth'(FracDigits);
        state_d  = ST_FRAC;
      end
      ST_FRAC: begin
        strobe_d = 1'b1;
        code_d   = CharZero + CharWidth'(frac_x10[FracWidth+3:FracWidth]);
        frac_d   = frac_x10[FracWidth-1:0];
        fcnt_d   = fcnt_q - 1'b1;
        if (fcnt_q == FcntWidth'(1)) begin
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    frac_q <= frac_d;
    idx_q  <= idx_d;
    fcnt_q <= fcnt_d;
    code_q <= code_d;
  end

  assign busy          = (state_q != ST_IDLE);
  assign char_strobe_o = strobe_q;
  assign char_code_o   = code_q;
  assign last_char_o   = last_q;

  // a beat only follows an emitting state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_strobe_o |-> ($past(state_q) == ST_SIGN || $past(state_q) == ST_INT ||
                       $past(state_q) == ST_DOT || $past(state_q) == ST_FRAC))
    else $error("beat without an emitting state");

  // last character is a fraction digit on a valid beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_char_o |-> (char_strobe_o && char_code_o >= CharZero && char_code_o <= CharNine))
    else $error("last character is not a digit beat");

  // accepted number starts the integer conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_CONV && !conv_done))
    else $error("accept did not start conversion");

  // the point is always followed by the fraction digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DOT) |=> (state_q == ST_FRAC && fcnt_q == FcntWidth'(FracDigits)))
    else $error("point not followed by fraction digits");

endmodule

### test/tb_top.sv
// testbench for the 16.16 fixed point to decimal text converter: directed table, then random numbers
module tb_top;
  import q16dt_pkg::*;

  typedef struct packed {
    logic [CharWidth-1:0] code;
    logic                 last;
  } text_beat_t;

  localparam int unsigned RandomCount = 288;
  localparam int unsigned DrainCycles = 40;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic signed [ValueWidth-1:0] value_i;
  logic                         char_strobe_o;
  logic        [CharWidth-1:0]  char_code_o;
  logic                         last_char_o;

  text_beat_t            pending_chars_q[$];
  logic [ValueWidth-1:0] table_value_q[$];
  string                 table_text_q[$];
  int unsigned           mismatch_count;
  int unsigned           beats_checked;
  int unsigned           numbers_sent;
  int unsigned           negatives_sent;
  int unsigned           burst_left;

  q16_16_to_decimal_text i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .char_strobe_o(char_strobe_o),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  task automatic push_text(input string text);
    byte ch;
    text_beat_t beat;
    for (int i = 0; i < text.len(); i++) begin
      ch = text.getc(i);
      beat.code = ch[CharWidth-1:0];
      beat.last = (i == text.len() - 1);
      pending_chars_q.push_back(beat);
    end
  endtask

  task automatic predict_text(input logic [ValueWidth-1:0] raw);
    logic [ValueWidth-1:0] mag;
    logic [31:0]           int_part;
    logic [31:0]           frac_prod;
    logic [31:0]           frac_part;
    logic [CharWidth-1:0]  chars[$];
    logic [3:0]            int_digits[$];
    text_beat_t            beat;
    mag = raw[ValueWidth-1] ? (32'd0 - raw) : raw;
    int_part = mag >> FracWidth;
    frac_prod = {16'd0, mag[FracWidth-1:0]} * 32'd15625;
    frac_part = frac_prod >> 10;
    if (raw[ValueWidth-1]) begin
      chars.push_back(CharMinus);
    end
    do begin
      int_digits.push_front(4'(int_part % 10));
      int_part = int_part / 10;
    end while (int_part != 0);
    foreach (int_digits[i]) begin
      chars.push_back(CharZero + 7'(int_digits[i]));
    end
    chars.push_back(CharDot);
    int_digits.delete();
    for (int i = 0; i < FracDigits; i++) begin
      int_digits.push_front(4'(frac_part % 10));
      frac_part = frac_part / 10;
    end
    foreach (int_digits[i]) begin
      chars.push_back(CharZero + 7'(int_digits[i]));
    end
    foreach (chars[i]) begin
      beat.code = chars[i];
      beat.last = (i == chars.size() - 1);
      pending_chars_q.push_back(beat);
    end
  endtask

  always @(posedge clk_i) begin
    text_beat_t want;
    if (rst_ni && char_strobe_o) begin
      if (pending_chars_q.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%0h", char_code_o));
      end else begin
        want = pending_chars_q.pop_front();
        beats_checked++;
        if (char_code_o !== want.code) begin
          report_mismatch($sformatf("char 0x%0h, want 0x%0h", char_code_o, want.code));
        end
        if (last_char_o !== want.last) begin
          report_mismatch($sformatf("last_char %b, want %b on char 0x%0h",
                                    last_char_o, want.last, want.code));
        end
      end
    end
  end

  task automatic add_row(input logic [ValueWidth-1:0] v, input string text);
    table_value_q.push_back(v);
    table_text_q.push_back(text);
  endtask

  // bursts of numbers with random gaps, some bursts back to back
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if ($urandom_range(0, 9) >= 3) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 25)) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_number(input logic [ValueWidth-1:0] v, input string text);
    pace_sender();
    value_i <= v;
    start   <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (text.len() == 0) begin
      predict_text(v);
    end else begin
      push_text(text);
    end
    numbers_sent++;
    if (v[ValueWidth-1]) negatives_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_chars_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [ValueWidth-1:0] pick_value();
    logic [ValueWidth-1:0] v;
    logic [15:0]           int_part;
    logic [15:0]           frac;
    int unsigned           kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      v = $urandom();
    end else if (kind < 90) begin
      if (kind < 65) begin
        int_part = 16'($urandom_range(0, 12));
      end else begin
        case ($urandom_range(0, 8))
          0: int_part = 16'd9;
          1: int_part = 16'd10;
          2: int_part = 16'd99;
          3: int_part = 16'd100;
          4: int_part = 16'd999;
          5: int_part = 16'd1000;
          6: int_part = 16'd9999;
          7: int_part = 16'd10000;
          default: int_part = 16'd32767;
        endcase
      end
      case ($urandom_range(0, 3))
        0: frac = 16'h0000;
        1: frac = 16'h0001;
        2: frac = 16'hFFFF;
        default: frac = 16'($urandom());
      endcase
      v = {int_part, frac};
      if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
    end else if (kind < 95) begin
      v = 32'h8000_0000 + 32'($urandom_range(0, 3));
    end else begin
      v = 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
    end
    return v;
  endfunction

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    value_i        = '0;
    mismatch_count = 0;
    beats_checked  = 0;
    numbers_sent   = 0;
    negatives_sent = 0;
    burst_left     = 0;

    add_row(32'h0000_0000, "0.000000");
    add_row(32'h0000_0001, "0.000015");
    add_row(32'hFFFF_FFFF, "-0.000015");
    add_row(32'h8000_0000, "-32768.000000");
    add_row(32'h7FFF_FFFF, "32767.999984");
    add_row(32'h0001_0000, "1.000000");
    add_row(32'hFFFF_0000, "-1.000000");
    add_row(32'h0000_8000, "0.500000");
    add_row(32'h0000_FFFF, "0.999984");
    add_row(32'h0000_0040, "0.000976");
    add_row(32'h0009_0000, "9.000000");
    add_row(32'h000A_0000, "10.000000");
    add_row(32'h0064_0000, "100.000000");
    add_row(32'h03E8_0000, "1000.000000");
    add_row(32'h2710_0000, "10000.000000");
    add_row(32'hD8F0_0000, "-10000.000000");
    add_row(32'h8000_0001, "");
    add_row(32'h8000_FFFF, "");
    add_row(32'h1234_5678, "");
    add_row(32'hEDCB_A988, "");
    add_row(32'h5555_AAAA, "");
    add_row(32'hAAAA_5555, "");

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (table_value_q[i]) begin
      send_number(table_value_q[i], table_text_q[i]);
    end
    wait_idle();

    for (int i = 0; i < RandomCount; i++) begin
      send_number(pick_value(), "");
      if (i == RandomCount / 2) wait_idle();
    end

    start <= 1'b0;
    while (pending_chars_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d numbers (%0d negative), checked %0d characters",
             numbers_sent, negatives_sent, beats_checked);
    $display("covered extremes, digit count boundaries, fraction edges and random values");
    if (mismatch_count == 0) begin
      $display("q16_16_to_decimal_text test passed");
    end else begin
      $display("q16_16_to_decimal_text test failed");
    end
    $finish;
  end

  initial begin
    #(12 * 300000);
    $display("timeout with %0d characters outstanding", pending_chars_q.size());
    $display("q16_16_to_decimal_text test failed");
    $finish;
  end

endmodule
